### hw/rtl/pab_pkg.sv
`default_nettype none
package pab_pkg;

  typedef enum logic [1:0] {
    FMT_BGRA8888 = 2'd0,
    FMT_ARGB4444 = 2'd1,
    FMT_RGB565   = 2'd2,
    FMT_GRAY8    = 2'd3
  } fmt_t;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 1'b1;

  localparam fmt_t FMT_RESET   = FMT_BGRA8888;
  localparam logic BLEND_RESET = 1'b1;

  typedef struct packed {
    fmt_t fmt;
    logic blend_en;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/pab_blend.sv
`default_nettype none
module pab_blend (
  input  wire pab_pkg::cfg_t                  cfg,
  input  wire logic [pab_pkg::PIX_W-1:0]      dst,
  input  wire logic [pab_pkg::PIX_W-1:0]      rep,
  output logic      [pab_pkg::PIX_W-1:0]      pixel
);

  logic [pab_pkg::PIX_W-1:0] mask;
  logic [pab_pkg::PIX_W-1:0] d;
  logic [pab_pkg::PIX_W-1:0] r;
  logic [pab_pkg::PIX_W-1:0] res_8888;
  logic [15:0]               res_4444;
  logic [7:0]                ra8, inv8;
  logic [3:0]                ra4, inv4;
  logic [8:0]                a8;
  logic [4:0]                a4;
  logic [15:0]               c8 [3];
  logic [7:0]                c4 [3];

  always_comb begin
    case (cfg.fmt)
      pab_pkg::FMT_BGRA8888: mask = 32'hffff_ffff;
      pab_pkg::FMT_GRAY8:    mask = 32'h0000_00ff;
      default:               mask = 32'h0000_ffff;
    endcase
  end

  assign d = dst & mask;
  assign r = rep & mask;

  // 8888: byte channels, weights ra and 255-ra
  assign ra8  = r[31:24];
  assign inv8 = 8'hff - ra8;
  assign a8   = {1'b0, d[31:24]} + {1'b0, ra8};

  // 4444: nibble channels, weights ra and 15-ra
  assign ra4  = r[15:12];
  assign inv4 = 4'hf - ra4;
  assign a4   = {1'b0, d[15:12]} + {1'b0, ra4};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c8[i] = 16'(d[8*i +: 8] * inv8) + 16'(r[8*i +: 8] * ra8);
      c4[i] = 8'(d[4*i +: 4] * inv4) + 8'(r[4*i +: 4] * ra4);
    end
  end

  assign res_8888 = {(a8[8] ? 8'hff : a8[7:0]), c8[2][15:8], c8[1][15:8], c8[0][15:8]};
  assign res_4444 = {(a4[4] ? 4'hf : a4[3:0]), c4[2][7:4], c4[1][7:4], c4[0][7:4]};

  always_comb begin
    pixel = r;
    if (cfg.blend_en) begin
      case (cfg.fmt)
        pab_pkg::FMT_BGRA8888: pixel = res_8888;
        pab_pkg::FMT_ARGB4444: pixel = {16'h0000, res_4444};
        default:               pixel = r;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pixel_alpha_blend.sv
`default_nettype none
// An input register feeds the blend into a result register on m_axis.
// Throughput: one pixel per cycle while m_axis_tready is high; with a
// chained ready, a pixel can enter while a result waits.
// Reset (rst, synchronous): both stages empty, pixel_format = BGRA8888,
// blend_enable = 1.
module pixel_alpha_blend (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pab_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [2*pab_pkg::PIX_W-1:0]       s_axis_tdata,  // rep_pixel (high), dst_pixel (low)
  input  wire logic                              s_axis_tlast,  // end_of_row
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [pab_pkg::PIX_W-1:0]         m_axis_tdata,  // out_pixel
  output logic                                   m_axis_tlast   // end_of_row_out
);

  pab_pkg::cfg_t             cfg;
  logic                      s0_valid;
  logic [pab_pkg::PIX_W-1:0] s0_dst;
  logic [pab_pkg::PIX_W-1:0] s0_rep;
  logic                      s0_last;
  logic                      s1_load;
  logic [pab_pkg::PIX_W-1:0] pixel_next;

  assign s1_load       = s0_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s0_valid || s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt      <= pab_pkg::FMT_RESET;
      cfg.blend_en <= pab_pkg::BLEND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pab_pkg::REG_PIXEL_FORMAT: cfg.fmt      <= pab_pkg::fmt_t'(cfg_data[1:0]);
        pab_pkg::REG_BLEND_ENABLE: cfg.blend_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s0_dst  <= s_axis_tdata[pab_pkg::PIX_W-1:0];
      s0_rep  <= s_axis_tdata[2*pab_pkg::PIX_W-1:pab_pkg::PIX_W];
      s0_last <= s_axis_tlast;
    end
  end

  pab_blend u_blend (
    .cfg   (cfg),
    .dst   (s0_dst),
    .rep   (s0_rep),
    .pixel (pixel_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= s0_valid;
    end
    if (s1_load) begin
      m_axis_tdata <= pixel_next;
      m_axis_tlast <= s0_last;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> s_axis_tready)
    else $error("input stage empty but not ready");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> m_axis_tvalid)
    else $error("loaded result not valid");

  a_gray_high_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_load && cfg.fmt == pab_pkg::FMT_GRAY8) |=> m_axis_tdata[31:8] == 24'h0)
    else $error("GRAY8 result has high bits set");

  a_overwrite_pass: assert property (@(posedge clk) disable iff (rst)
    (s1_load && !cfg.blend_en && cfg.fmt == pab_pkg::FMT_BGRA8888)
      |=> m_axis_tdata == $past(s0_rep))
    else $error("overwrite result differs from replacement");

endmodule
`default_nettype wire

### tb/tb_pixel_alpha_blend.sv
module tb_pixel_alpha_blend;
  import pab_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_PIXELS = 65;

  typedef struct packed {
    logic [31:0] pixel;
    logic        eor;
  } blend_out_t;

  typedef struct packed {
    fmt_t        fmt;
    logic        blend;
    logic [31:0] dst;
    logic [31:0] rep;
    logic        eor;
    logic        known;
    logic [31:0] want;
  } blit_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2*PIX_W-1:0] s_axis_tdata = '0;  // rep_pixel (high), dst_pixel (low)
  logic s_axis_tlast = 1'b0;              // end_of_row
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;         // out_pixel
  logic m_axis_tlast;                     // end_of_row_out

  pixel_alpha_blend u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  fmt_t       cur_fmt = FMT_RESET;
  logic       cur_blend = BLEND_RESET;
  blend_out_t pix_due[$];
  bit         no_idle = 1'b0;
  int         errors = 0;
  int         pixels_sent = 0;
  int         pixels_checked = 0;
  int         idle_cycles = 0;
  int         sink_wait = 0;

  localparam int N_CASES = 20;
  blit_case_t blit_cases [N_CASES] = '{
    '{FMT_BGRA8888, 1'b1, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 32'h00000000},
    '{FMT_BGRA8888, 1'b1, 32'h00000000, 32'hffffffff, 1'b0, 1'b1, 32'hfffefefe},
    '{FMT_BGRA8888, 1'b1, 32'hffffffff, 32'h00000000, 1'b1, 1'b1, 32'hfffefefe},
    '{FMT_BGRA8888, 1'b1, 32'hff000000, 32'hff000000, 1'b0, 1'b1, 32'hff000000},
    '{FMT_BGRA8888, 1'b1, 32'h80402010, 32'h7f112233, 1'b0, 1'b0, 32'h0},
    '{FMT_BGRA8888, 1'b1, 32'ha5a5a5a5, 32'h005a5a5a, 1'b1, 1'b0, 32'h0},
    '{FMT_ARGB4444, 1'b1, 32'hffffffff, 32'hffffffff, 1'b0, 1'b1, 32'h0000feee},
    '{FMT_ARGB4444, 1'b1, 32'h0000ffff, 32'h00000000, 1'b0, 1'b1, 32'h0000feee},
    '{FMT_ARGB4444, 1'b1, 32'h12345678, 32'habcd8f3c, 1'b1, 1'b0, 32'h0},
    '{FMT_ARGB4444, 1'b1, 32'h00000000, 32'h0000f123, 1'b0, 1'b0, 32'h0},
    '{FMT_RGB565,   1'b1, 32'hffffffff, 32'hdeadbeef, 1'b0, 1'b1, 32'h0000beef},
    '{FMT_RGB565,   1'b1, 32'h00000000, 32'hffffffff, 1'b1, 1'b1, 32'h0000ffff},
    '{FMT_GRAY8,    1'b1, 32'hffffffff, 32'h12345678, 1'b0, 1'b1, 32'h00000078},
    '{FMT_GRAY8,    1'b0, 32'h00000000, 32'habcdef01, 1'b1, 1'b1, 32'h00000001},
    '{FMT_RGB565,   1'b0, 32'hffffffff, 32'h12345678, 1'b0, 1'b1, 32'h00005678},
    '{FMT_ARGB4444, 1'b0, 32'hffffffff, 32'hffff0000, 1'b0, 1'b1, 32'h00000000},
    '{FMT_BGRA8888, 1'b0, 32'h00000000, 32'h12345678, 1'b0, 1'b1, 32'h12345678},
    '{FMT_BGRA8888, 1'b0, 32'hffffffff, 32'h00ffffff, 1'b1, 1'b1, 32'h00ffffff},
    '{FMT_BGRA8888, 1'b1, 32'h01020304, 32'h80ffffff, 1'b0, 1'b0, 32'h0},
    '{FMT_BGRA8888, 1'b1, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 32'hfffefefe}
  };

  function automatic logic [31:0] mix_pixel(logic [31:0] d_in, logic [31:0] r_in,
                                            fmt_t fmt, logic blend);
    logic [31:0] mask;
    logic [31:0] d;
    logic [31:0] r;
    logic [31:0] res;
    logic [15:0] acc;
    logic [8:0]  a_sum;
    logic [7:0]  ra;
    logic [7:0]  inv;
    int          i;
    case (fmt)
      FMT_BGRA8888: mask = 32'hffffffff;
      FMT_GRAY8:    mask = 32'h000000ff;
      default:      mask = 32'h0000ffff;
    endcase
    d = d_in & mask;
    r = r_in & mask;
    res = r;
    if (blend && fmt == FMT_BGRA8888) begin
      ra = r[31:24];
      inv = 8'hff - ra;
      for (i = 0; i < 3; i++) begin
        acc = d[8*i +: 8] * inv + r[8*i +: 8] * ra;
        res[8*i +: 8] = acc[15:8];
      end
      a_sum = d[31:24] + r[31:24];
      res[31:24] = (a_sum > 9'hff) ? 8'hff : a_sum[7:0];
    end else if (blend && fmt == FMT_ARGB4444) begin
      ra = {4'h0, r[15:12]};
      inv = 8'h0f - ra;
      for (i = 0; i < 3; i++) begin
        acc = r[4*i +: 4] * ra + d[4*i +: 4] * inv;
        res[4*i +: 4] = acc[7:4];
      end
      a_sum = d[15:12] + r[15:12];
      res[15:12] = (a_sum > 9'h00f) ? 4'hf : a_sum[3:0];
    end
    return res & mask;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 15) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[31:24] = 8'h00;
      1: v[31:24] = 8'hff;
      2: v[15:12] = 4'h0;
      3: v[15:12] = 4'hf;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic push_pixel(input logic [31:0] dst, input logic [31:0] rep, input logic eor,
                            input logic known, input logic [31:0] want);
    blend_out_t e;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rep, dst};
    s_axis_tlast  <= eor;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    e.pixel = known ? want : mix_pixel(dst, rep, cur_fmt, cur_blend);
    e.eor = eor;
    pix_due.push_back(e);
    pixels_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pix_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mode(input fmt_t fmt, input logic blend);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data  <= CFG_DATA_W'(fmt);
    @(posedge clk);
    cfg_index <= REG_BLEND_ENABLE;
    cfg_data  <= CFG_DATA_W'(blend);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fmt = fmt;
    cur_blend = blend;
  endtask

  initial begin
    blit_case_t c;
    int ph;
    int k;
    fmt_t f;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < N_CASES; k++) begin
      c = blit_cases[k];
      if (c.fmt != cur_fmt || c.blend != cur_blend) set_mode(c.fmt, c.blend);
      push_pixel(c.dst, c.rep, c.eor, c.known, c.want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      f = fmt_t'($urandom_range(0, 3));
      set_mode(f, ph == 1 ? 1'b0 : (ph == 2 ? 1'b1 : 1'($urandom_range(0, 1))));
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_PIXELS; k++)
        push_pixel(rand_pixel(), rand_pixel(), 1'($urandom_range(0, 7) == 0), 1'b0, 32'h0);
    end
    no_idle = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("%0d pixels checked of %0d sent, all pixel formats in blend and overwrite modes",
             pixels_checked, pixels_sent);
    if (errors == 0) begin
      $display("tb_pixel_alpha_blend: clean");
    end else begin
      $display("tb_pixel_alpha_blend: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else if (!rst && !no_idle && $urandom_range(0, 3) == 0) begin
      sink_wait = pick_gap() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    blend_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pix_due.size() == 0) begin
        $error("unexpected transfer: out_pixel %h end_of_row_out %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pix_due.pop_front();
        pixels_checked++;
        if (m_axis_tdata !== want.pixel) begin
          $error("out_pixel: expected %h, got %h", want.pixel, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.eor) begin
          $error("end_of_row_out: expected %b, got %b", want.eor, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pix_due.size());
      $display("tb_pixel_alpha_blend: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### pixel_alpha_blend.f
hw/rtl/pab_pkg.sv
hw/rtl/pab_blend.sv
hw/rtl/pixel_alpha_blend.sv
tb/tb_pixel_alpha_blend.sv
